// ----- design/assert_macros.svh -----
// shared assertion macros, sampled on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition true at every edge
`define CHECK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent in the same cycle as the antecedent
`define CHECK_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lkvc_pkg.sv -----
package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } lkvc_req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } lkvc_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic upd;
    logic resp;
    logic cfg_wr;
  } lkvc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic is_get;
    logic hit;
    logic rsp_busy;
  } lkvc_sts_t;

endpackage

// ----- design/lkvc_ram.sv -----
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lkvc_ctrl.sv -----
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  lkvc_sts_t sts,
  output lkvc_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_SCAN_END = 7'b0000100,
    S_COMMIT   = 7'b0001000,
    S_UPD      = 7'b0010000,
    S_UPD_END  = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    cfg_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        cfg_ready = 1'b1;
        req_ready = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
        end else if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        if (sts.is_get && !sts.hit) begin
          state_next = S_RESP;
        end else begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.last) begin
          state_next = S_UPD_END;
        end
      end
      S_UPD_END: begin
        state_next = sts.is_get ? S_RESP : S_IDLE;
      end
      S_RESP: begin
        if (!sts.rsp_busy) begin
          cmd.resp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lkvc_dp.sv -----
module lkvc_dp import lkvc_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  lkvc_cmd_t        cmd,
  output lkvc_sts_t        sts,
  input  lkvc_req_t        req,
  input  logic [CAP_W-1:0] cfg_data,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output lkvc_rsp_t        rsp
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  // control state
  logic [CAP_W-1:0]       cap;
  logic [MAX_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       idx;
  logic                   pend;
  logic                   hit;
  logic                   have_vic;
  logic                   have_free;

  // payload
  lkvc_req_t        req_q;
  logic             pend_upd;
  logic [IDX_W-1:0] pend_idx;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic [VAL_W-1:0] hit_value;
  logic [IDX_W-1:0] vic_idx;
  logic [IDX_W-1:0] vic_rank;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] tgt;
  logic [IDX_W-1:0] thr;
  logic             fill_all;
  lkvc_rsp_t        rsp_q;

  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic [IDX_W-1:0] rank_rd;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             full;
  logic             is_put;
  logic             ent_valid;
  logic             scan_eval;
  logic             match;
  logic [IDX_W-1:0] tgt_sel;
  logic             key_we;
  logic             val_we;
  logic             rank_we;
  logic [IDX_W-1:0] rank_wdata;

  always_comb begin
    cap_ext = CMP_W'(cap);
    if (cap == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full       = CMP_W'(count) >= eff_cap;
    is_put     = (req_q.mode == MODE_PUT);
    ent_valid  = valid[pend_idx];
    scan_eval  = pend && !pend_upd;
    match      = scan_eval && ent_valid && (key_rd == $unsigned(req_q.key));
    tgt_sel    = hit ? hit_idx : (full ? vic_idx : free_idx);
    key_we     = cmd.commit && is_put && !hit;
    val_we     = cmd.commit && is_put;
    rank_we    = pend && pend_upd &&
                 ((pend_idx == tgt) || (ent_valid && (fill_all || (rank_rd < thr))));
    rank_wdata = (pend_idx == tgt) ? '0 : rank_rd + 1'b1;
  end

  lkvc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (tgt_sel),
    .wdata ($unsigned(req_q.key)),
    .raddr (idx),
    .rdata (key_rd)
  );

  lkvc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (tgt_sel),
    .wdata ($unsigned(req_q.value)),
    .raddr (idx),
    .rdata (val_rd)
  );

  lkvc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (pend_idx),
    .wdata (rank_wdata),
    .raddr (idx),
    .rdata (rank_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_RESET;
      valid     <= '0;
      count     <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      have_vic  <= 1'b0;
      have_free <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pend <= cmd.scan || cmd.upd;
      if (cmd.scan || cmd.upd) begin
        idx <= idx + 1'b1;
      end
      if (cmd.load) begin
        idx       <= '0;
        hit       <= 1'b0;
        have_vic  <= 1'b0;
        have_free <= 1'b0;
      end
      if (scan_eval) begin
        if (match && !hit) begin
          hit <= 1'b1;
        end
        if (ent_valid && (!have_vic || (rank_rd > vic_rank))) begin
          have_vic <= 1'b1;
        end
        if (!ent_valid && !have_free) begin
          have_free <= 1'b1;
        end
      end
      if (cmd.commit) begin
        idx <= '0;
        if (is_put && !hit && !full) begin
          valid[free_idx] <= 1'b1;
          count           <= count + 1'b1;
        end
      end
      if (cmd.resp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.cfg_wr) begin
        cap   <= cfg_data;
        valid <= '0;
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_upd <= cmd.upd;
    pend_idx <= idx;
    if (cmd.load) begin
      req_q <= req;
    end
    if (scan_eval) begin
      if (match && !hit) begin
        hit_idx   <= pend_idx;
        hit_rank  <= rank_rd;
        hit_value <= val_rd;
      end
      if (ent_valid && (!have_vic || (rank_rd > vic_rank))) begin
        vic_idx  <= pend_idx;
        vic_rank <= rank_rd;
      end
      if (!ent_valid && !have_free) begin
        free_idx <= pend_idx;
      end
    end
    if (cmd.commit) begin
      tgt      <= tgt_sel;
      thr      <= hit ? hit_rank : vic_rank;
      fill_all <= !hit && !full;
    end
    if (cmd.resp) begin
      rsp_q.found      <= hit;
      rsp_q.read_value <= hit ? $signed(hit_value) : $signed(MISS_VALUE);
    end
  end

  always_comb begin
    sts.last     = (idx == LAST_IDX);
    sts.is_get   = (req_q.mode == MODE_GET);
    sts.hit      = hit;
    sts.rsp_busy = rsp_valid && !rsp_ready;
    rsp          = rsp_q;
  end

endmodule

// ----- design/lru_key_value_cache.sv -----
// fully associative key-value cache with least-recently-used replacement, up to
// MAX_ENTRIES entries; a get beat (mode 0) returns one rsp beat with found and the
// stored value, or found 0 and all-ones on a miss; a put beat (mode 1) updates a
// present key, fills the lowest free entry, or evicts the least recent entry once
// the entry count reaches capacity_limit (0 acts as 1, above MAX_ENTRIES acts as
// MAX_ENTRIES), and returns nothing; one item is in work at a time; the key,
// value and rank memories each have a single read port, which one pass walks
// entry by entry for the search and a second pass, skipped on a get miss, for
// the recency update; a finished rsp beat waits in an output register while the
// next req beat is accepted; a cfg beat, taken only while no item is in work,
// sets the capacity and empties the cache at once
`include "assert_macros.svh"

module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             req_valid,
  output logic             req_ready,
  input  lkvc_req_t        req,
  // response channel
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output lkvc_rsp_t        rsp,
  // capacity register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  // command and status between sequencer and datapath
  lkvc_cmd_t cmd;
  lkvc_sts_t sts;

  // sequencer: idle, search pass, commit, recency pass, response
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry memories, valid bits, entry count, capacity and output register
  lkvc_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // at most one datapath command per cycle
  `CHECK_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")

  // a cfg beat and a req beat never land on the same edge
  `CHECK_ALWAYS(a_cfg_req_excl, !(cfg_valid && cfg_ready && req_valid && req_ready), "cfg and req beats accepted together")

  // one item at a time: ready drops right after a req beat
  `CHECK_NEXT(a_one_item, req_valid && req_ready, !req_ready, "req accepted while an item is in work")

  // a response only appears after the sequencer issues it
  `CHECK_IMPLIES(a_rsp_source, $rose(rsp_valid), $past(cmd.resp), "rsp_valid rose without a response command")

endmodule
